[sv/checksummed_sentence_decoder_top_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef CHECKSUMMED_SENTENCE_DECODER_TOP_MACROS_SVH
`define CHECKSUMMED_SENTENCE_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define CSD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CSD_ASSERT(lbl, prop, msg)
`define CSD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[sv/csd_pkg.sv]
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types, character codes and tables of the sentence decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package csd_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 128;
    localparam int unsigned EVQ_DEPTH       = 4;
    localparam int unsigned EVQ_AW          = $clog2(EVQ_DEPTH);
    localparam int unsigned EVQ_CW          = $clog2(EVQ_DEPTH + 1);
    localparam int unsigned RQ_DEPTH        = 2;
    localparam int unsigned CAPS_N          = 6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_ENVELOPE = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_COUNT    = 3'd4;
    localparam logic [2:0] ST_TYPE     = 3'd5;
    localparam logic [2:0] ST_NUMBER   = 3'd6;
    localparam logic [2:0] ST_RANGE    = 3'd7;

    // bit positions in the field flag register
    localparam int unsigned MK_BAD    = 0;
    localparam int unsigned MK_DIGIT  = 1;
    localparam int unsigned MK_NEG    = 2;
    localparam int unsigned MK_TYPE   = 3;
    localparam int unsigned MK_NUMBER = 4;
    localparam int unsigned MK_KIND   = 7;

    localparam logic [32:0] ACC_CAP = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        EV_START,
        EV_PAY,
        EV_CRS,
        EV_FIN,
        EV_OVF
    } t_ev_kind;

    typedef struct packed {
        t_ev_kind   kind;
        logic [7:0] data;   // payload byte, checksum, or kind in bit 0
        logic [7:0] cnt;    // carriage return count
        logic       env_ok;
    } t_event;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        sequence_res;
        logic               has_person;
        logic [6:0]         score;
        logic [11:0]        det_col;
        logic [11:0]        det_row;
        logic               in_zone;
        logic               link_up;
        logic               srv_ok;
        logic signed [7:0]  signal_strength;
        logic [31:0]        epoch_sec;
    } t_result;

    function automatic logic [7:0] tag_char(input logic net, input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = net ? 8'h4E : 8'h56;
            2'd1:    c = net ? 8'h45 : 8'h49;
            2'd2:    c = net ? 8'h54 : 8'h53;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] field_limit(input logic net, input logic [2:0] idx);
        logic [31:0] l;
        case (idx)
            3'd1:    l = net ? 32'd1 : 32'd65535;
            3'd2:    l = 32'd1;
            3'd3:    l = net ? 32'd0 : 32'd100;
            3'd4:    l = net ? 32'hFFFF_FFFF : 32'd4095;
            3'd5:    l = 32'd4095;
            3'd6:    l = 32'd1;
            default: l = 32'd0;
        endcase
        return l;
    endfunction

endpackage
`default_nettype wire

[sv/checksummed_sentence_decoder_top.sv]
// ----------------------------------------------------------------------------
// checksummed_sentence_decoder_top
// Sentence decoder: framing front end, event queue, field-check back end.
// Throughput: one byte per cycle while full is low; a byte that ends a run of
//   non-trailing carriage returns holds full while the held run is replayed;
//   full also holds while the event queue is full behind a stalled reader.
// Result path: a newline's finish event is registered in the event queue, then its result in the result queue.
// Reset: synchronous active-low; clears framing, queues and the kind select r_kind.
// ----------------------------------------------------------------------------
`default_nettype none
module checksummed_sentence_decoder_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    output logic                    empty,
    input  wire logic               pop,
    output logic [2:0]              o_status,
    output logic [15:0]             o_sequence_res,
    output logic                    o_has_person,
    output logic [6:0]              o_score,
    output logic [11:0]             o_det_col,
    output logic [11:0]             o_det_row,
    output logic                    o_in_zone,
    output logic                    o_link_up,
    output logic                    o_srv_ok,
    output logic signed [7:0]       o_signal_strength,
    output logic [31:0]             o_epoch_sec
);
    import csd_pkg::*;

    logic    fe_push, evq_ready, evq_valid, be_pop;
    t_event  fe_ev, evq_ev;
    t_result res;

    csd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_rx_byte  (i_rx_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_ev_push  (fe_push),
        .o_ev       (fe_ev),
        .i_ev_ready (evq_ready)
    );

    csd_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_ev    (fe_ev),
        .o_ready (evq_ready),
        .i_pop   (be_pop),
        .o_ev    (evq_ev),
        .o_valid (evq_valid)
    );

    csd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ev      (evq_ev),
        .i_ev_valid(evq_valid),
        .o_ev_pop  (be_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_res     (res)
    );

    assign o_status          = res.status;
    assign o_sequence_res    = res.sequence_res;
    assign o_has_person      = res.has_person;
    assign o_score           = res.score;
    assign o_det_col         = res.det_col;
    assign o_det_row         = res.det_row;
    assign o_in_zone         = res.in_zone;
    assign o_link_up         = res.link_up;
    assign o_srv_ok          = res.srv_ok;
    assign o_signal_strength = res.signal_strength;
    assign o_epoch_sec       = res.epoch_sec;

endmodule
`default_nettype wire

[sv/csd_front.sv]
// ----------------------------------------------------------------------------
// csd_front
// Frames the byte stream, holds back trailing carriage returns and the
// three-byte tail window, and issues frame events to the event queue.
// ----------------------------------------------------------------------------
`default_nettype none
module csd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_wdata,
    output logic                 o_ev_push,
    output csd_pkg::t_event      o_ev,
    input  wire logic            i_ev_ready
);
    import csd_pkg::*;
    `include "checksummed_sentence_decoder_top_macros.svh"

    logic        r_kind;
    logic        r_active, n_active;
    logic [7:0]  r_flen, n_flen;
    logic [7:0]  r_cr, n_cr;
    logic [7:0]  r_held, n_held;
    logic [23:0] r_tail, n_tail;
    logic        r_busy, n_busy;
    logic [7:0]  r_crleft, n_crleft;
    logic [1:0]  r_crdone, n_crdone;
    logic [7:0]  r_pend, n_pend;

    logic        accept;
    logic        held3;
    logic [4:0]  hx_hi, hx_lo;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
        else                               v = 5'h10;
        return v;
    endfunction

    assign o_full = r_busy || !i_ev_ready;
    assign accept = i_push && !o_full;
    assign held3  = r_held >= 8'd3;
    assign hx_hi  = hex_val(r_tail[15:8]);
    assign hx_lo  = hex_val(r_tail[7:0]);

    always_comb begin
        n_active  = r_active;
        n_flen    = r_flen;
        n_cr      = r_cr;
        n_held    = r_held;
        n_tail    = r_tail;
        n_busy    = r_busy;
        n_crleft  = r_crleft;
        n_crdone  = r_crdone;
        n_pend    = r_pend;
        o_ev_push = 1'b0;
        o_ev      = '{kind: EV_PAY, data: r_tail[23:16], cnt: 8'd0, env_ok: 1'b0};
        if (r_busy) begin
            if (i_ev_ready) begin
                if (r_crleft != 8'd0) begin
                    if (r_crdone == 2'd3) begin
                        // window is all CR: release the rest of the run at once
                        o_ev_push = 1'b1;
                        o_ev.kind = EV_CRS;
                        o_ev.cnt  = r_crleft;
                        n_held    = r_held + r_crleft;
                        n_crleft  = 8'd0;
                    end else begin
                        o_ev_push = held3;
                        n_tail    = {r_tail[15:0], CH_CR};
                        n_held    = r_held + 8'd1;
                        n_crleft  = r_crleft - 8'd1;
                        n_crdone  = r_crdone + 2'd1;
                    end
                end else begin
                    o_ev_push = held3;
                    n_tail    = {r_tail[15:0], r_pend};
                    n_held    = r_held + 8'd1;
                    n_busy    = 1'b0;
                end
            end
        end else if (accept) begin
            if (i_rx_byte == CH_DOLLAR) begin
                n_active  = 1'b1;
                n_flen    = 8'd1;
                n_cr      = 8'd0;
                n_held    = 8'd0;
                n_tail    = 24'd0;
                o_ev_push = 1'b1;
                o_ev.kind = EV_START;
                o_ev.data = {7'd0, r_kind};
            end else if (r_active) begin
                if (i_rx_byte == CH_LF) begin
                    n_active    = 1'b0;
                    o_ev_push   = 1'b1;
                    o_ev.kind   = EV_FIN;
                    o_ev.data   = {hx_hi[3:0], hx_lo[3:0]};
                    o_ev.env_ok = (r_held >= 8'd6) && (r_tail[23:16] == CH_STAR) &&
                                  !hx_hi[4] && !hx_lo[4];
                end else if (r_flen >= 8'(MAX_FRAME_BYTES)) begin
                    n_active  = 1'b0;
                    n_flen    = 8'd0;
                    o_ev_push = 1'b1;
                    o_ev.kind = EV_OVF;
                end else begin
                    n_flen = r_flen + 8'd1;
                    if (i_rx_byte == CH_CR) begin
                        n_cr = r_cr + 8'd1;
                    end else if (r_cr != 8'd0) begin
                        // held CRs turn out to be content: replay them first
                        n_busy   = 1'b1;
                        n_crleft = r_cr;
                        n_crdone = 2'd0;
                        n_pend   = i_rx_byte;
                        n_cr     = 8'd0;
                    end else begin
                        o_ev_push = held3;
                        n_tail    = {r_tail[15:0], i_rx_byte};
                        n_held    = r_held + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= 1'b0;
            r_active <= 1'b0;
            r_flen   <= 8'd0;
            r_cr     <= 8'd0;
            r_held   <= 8'd0;
            r_tail   <= 24'd0;
            r_busy   <= 1'b0;
            r_crleft <= 8'd0;
            r_crdone <= 2'd0;
            r_pend   <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_kind <= i_cfg_wdata;
            end
            r_active <= n_active;
            r_flen   <= n_flen;
            r_cr     <= n_cr;
            r_held   <= n_held;
            r_tail   <= n_tail;
            r_busy   <= n_busy;
            r_crleft <= n_crleft;
            r_crdone <= n_crdone;
            r_pend   <= n_pend;
        end
    end

    `CSD_ASSERT(a_fe_busy_active, !r_busy || r_active, "replay outside an open frame")
    `CSD_ASSERT(a_fe_no_accept_busy, !(accept && r_busy), "byte taken during replay")

endmodule
`default_nettype wire

[sv/csd_evq.sv]
// ----------------------------------------------------------------------------
// csd_evq
// Short event queue between the framing front end and the field back end.
// ----------------------------------------------------------------------------
`default_nettype none
module csd_evq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  csd_pkg::t_event      i_ev,
    output logic                 o_ready,
    input  wire logic            i_pop,
    output csd_pkg::t_event      o_ev,
    output logic                 o_valid
);
    import csd_pkg::*;
    `include "checksummed_sentence_decoder_top_macros.svh"

    t_event              r_mem [EVQ_DEPTH];
    logic [EVQ_AW-1:0]   r_wr, r_rd;
    logic [EVQ_CW-1:0]   r_count;
    logic                do_push, do_pop;

    assign o_ready = r_count != EVQ_CW'(EVQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_ev    = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + EVQ_AW'(1);
            if (do_pop)  r_rd <= r_rd + EVQ_AW'(1);
            if (do_push && !do_pop)      r_count <= r_count + EVQ_CW'(1);
            else if (do_pop && !do_push) r_count <= r_count - EVQ_CW'(1);
        end
    end

    `CSD_ASSERT(a_evq_no_drop, !i_push || o_ready, "event offered to a full queue")
    `CSD_ASSERT_NEXT(a_evq_grow, do_push && !do_pop, r_count == $past(r_count) + EVQ_CW'(1), "count slip")

endmodule
`default_nettype wire

[sv/csd_back.sv]
// ----------------------------------------------------------------------------
// csd_back
// Checks fields one event per cycle; a result waits while its queue is full.
// ----------------------------------------------------------------------------
`default_nettype none
module csd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  csd_pkg::t_event      i_ev,
    input  wire logic            i_ev_valid,
    output logic                 o_ev_pop,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output csd_pkg::t_result     o_res
);
    import csd_pkg::*;
    `include "checksummed_sentence_decoder_top_macros.svh"

    logic [32:0] r_acc, n_acc;
    logic [3:0]  r_fnum, n_fnum;
    logic [7:0]  r_marks, n_marks;
    logic [7:0]  r_xor, n_xor;
    logic [31:0] r_caps [CAPS_N];
    logic [31:0] n_caps [CAPS_N];

    t_result     r_rq [RQ_DEPTH];
    logic        r_rq_wr, r_rq_rd;
    logic [1:0]  r_rq_cnt;

    logic [7:0]  cf_marks;
    logic [31:0] cf_caps [CAPS_N];
    logic [3:0]  cf_fnum;
    logic        cf_ok;
    logic [31:0] cf_val;

    logic        net;
    logic        is_res, res_push, rq_pop;
    logic [7:0]  p;
    logic [36:0] mul;
    logic [8:0]  cr_sum;
    t_result     res;

    assign net      = r_marks[MK_KIND];
    assign p        = i_ev.data;
    assign is_res   = (i_ev.kind == EV_FIN) || (i_ev.kind == EV_OVF);
    assign o_ev_pop = i_ev_valid && (!is_res || (r_rq_cnt != 2'(RQ_DEPTH)));
    assign res_push = o_ev_pop && is_res;
    assign rq_pop   = i_pop && !o_empty;
    assign o_empty  = r_rq_cnt == 2'd0;
    assign o_res    = r_rq[r_rq_rd];

    // close the current field
    always_comb begin
        cf_marks = r_marks;
        cf_caps  = r_caps;
        cf_ok    = 1'b0;
        cf_val   = 32'd0;
        if (r_fnum == 4'd0) begin
            if (r_marks[MK_BAD] || r_acc != 33'd3) cf_marks[MK_TYPE] = 1'b1;
        end else if (r_fnum <= (net ? 4'd4 : 4'd6)) begin
            cf_ok = r_marks[MK_DIGIT] && !r_marks[MK_BAD];
            if (net && r_fnum == 4'd3) begin
                if (r_marks[MK_NEG]) begin
                    cf_ok  = cf_ok && (r_acc <= 33'd127);
                    cf_val = 32'd0 - r_acc[31:0];
                end else begin
                    cf_ok = cf_ok && (r_acc == 33'd0);
                end
            end else begin
                cf_ok  = cf_ok && !r_marks[MK_NEG] &&
                         (r_acc <= {1'b0, field_limit(net, r_fnum[2:0])});
                cf_val = r_acc[31:0];
            end
            if (cf_ok) cf_caps[r_fnum[2:0] - 3'd1] = cf_val;
            else       cf_marks[MK_NUMBER] = 1'b1;
        end
        cf_marks[MK_BAD]   = 1'b0;
        cf_marks[MK_DIGIT] = 1'b0;
        cf_marks[MK_NEG]   = 1'b0;
        cf_fnum = (r_fnum == 4'd15) ? r_fnum : r_fnum + 4'd1;
    end

    assign mul    = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + 37'(p - CH_ZERO);
    assign cr_sum = 9'(r_acc[3:0]) + 9'(i_ev.cnt);

    always_comb begin
        n_acc   = r_acc;
        n_fnum  = r_fnum;
        n_marks = r_marks;
        n_xor   = r_xor;
        n_caps  = r_caps;
        res     = '0;
        case (i_ev.kind)
            EV_START: begin
                n_acc   = 33'd0;
                n_fnum  = 4'd0;
                n_marks = {i_ev.data[0], 7'd0};
                n_xor   = 8'd0;
                for (int i = 0; i < CAPS_N; i++) n_caps[i] = 32'd0;
            end
            EV_PAY: begin
                n_xor = r_xor ^ p;
                if (p == CH_COMMA) begin
                    n_marks = cf_marks;
                    n_caps  = cf_caps;
                    n_acc   = 33'd0;
                    n_fnum  = cf_fnum;
                end else if (r_fnum == 4'd0) begin
                    if (!(r_acc < 33'd3 && p == tag_char(net, r_acc[1:0])))
                        n_marks[MK_BAD] = 1'b1;
                    if (r_acc < 33'd4) n_acc = r_acc + 33'd1;
                end else if (p >= CH_ZERO && p <= CH_NINE) begin
                    n_acc = (mul > 37'(ACC_CAP)) ? ACC_CAP : mul[32:0];
                    n_marks[MK_DIGIT] = 1'b1;
                end else if (p == CH_MINUS && net && r_fnum == 4'd3 &&
                             !r_marks[MK_DIGIT] && !r_marks[MK_NEG] && !r_marks[MK_BAD]) begin
                    n_marks[MK_NEG] = 1'b1;
                end else begin
                    n_marks[MK_BAD] = 1'b1;
                end
            end
            EV_CRS: begin
                n_xor = r_xor ^ (i_ev.cnt[0] ? CH_CR : 8'd0);
                n_marks[MK_BAD] = 1'b1;
                if (r_fnum == 4'd0) n_acc = (cr_sum > 9'd4) ? 33'd4 : 33'(cr_sum);
            end
            EV_FIN: begin
                n_marks = cf_marks;
                n_caps  = cf_caps;
                n_acc   = 33'd0;
                n_fnum  = cf_fnum;
                if (!i_ev.env_ok)                          res.status = ST_ENVELOPE;
                else if (r_xor != i_ev.data)               res.status = ST_CHECKSUM;
                else if (r_fnum != (net ? 4'd4 : 4'd6))    res.status = ST_COUNT;
                else if (cf_marks[MK_TYPE])                res.status = ST_TYPE;
                else if (cf_marks[MK_NUMBER])              res.status = ST_NUMBER;
                else if (net) begin
                    if (cf_caps[1] != 32'd0 && cf_caps[0] == 32'd0) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.status          = ST_OK;
                        res.link_up         = cf_caps[0][0];
                        res.srv_ok          = cf_caps[1][0];
                        res.signal_strength = cf_caps[2][7:0];
                        res.epoch_sec       = cf_caps[3];
                    end
                end else begin
                    if (cf_caps[1] == 32'd0 &&
                        (cf_caps[2] | cf_caps[3] | cf_caps[4] | cf_caps[5]) != 32'd0) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.status       = ST_OK;
                        res.sequence_res = cf_caps[0][15:0];
                        res.has_person   = cf_caps[1][0];
                        res.score        = cf_caps[2][6:0];
                        res.det_col      = cf_caps[3][11:0];
                        res.det_row      = cf_caps[4][11:0];
                        res.in_zone      = cf_caps[5][0];
                    end
                end
            end
            EV_OVF: begin
                res.status = ST_DROPPED;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_rq[r_rq_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 33'd0;
            r_fnum   <= 4'd0;
            r_marks  <= 8'd0;
            r_xor    <= 8'd0;
            for (int i = 0; i < CAPS_N; i++) r_caps[i] <= 32'd0;
            r_rq_wr  <= 1'b0;
            r_rq_rd  <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            if (o_ev_pop) begin
                r_acc   <= n_acc;
                r_fnum  <= n_fnum;
                r_marks <= n_marks;
                r_xor   <= n_xor;
                r_caps  <= n_caps;
            end
            if (res_push) r_rq_wr <= ~r_rq_wr;
            if (rq_pop)   r_rq_rd <= ~r_rq_rd;
            if (res_push && !rq_pop)      r_rq_cnt <= r_rq_cnt + 2'd1;
            else if (rq_pop && !res_push) r_rq_cnt <= r_rq_cnt - 2'd1;
        end
    end

    `CSD_ASSERT(a_be_rq_bound, r_rq_cnt <= 2'(RQ_DEPTH), "result queue overrun")
    `CSD_ASSERT(a_be_clean, o_empty || o_res.status == ST_OK || o_res.epoch_sec == 32'd0, "stray fields")

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the checksummed sentence decoder. Bytes go in through the push
// side, results come back through the pop side, and a byte-level predictor
// of the frame, checksum and field rules supplies the expected results in
// order. Directed frames cover limits and corner cases, then random
// well-formed and damaged sentences run under several idle/stall phases.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csd_pkg::*;

    localparam int RUN_LIMIT = 600000;
    localparam int RANDOM_BYTES = 1200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        pop = 1'b0;
    logic        full, empty;
    wire t_result seen;

    checksummed_sentence_decoder_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_rx_byte          (i_rx_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .empty              (empty),
        .pop                (pop),
        .o_status           (seen.status),
        .o_sequence_res     (seen.sequence_res),
        .o_has_person       (seen.has_person),
        .o_score            (seen.score),
        .o_det_col          (seen.det_col),
        .o_det_row          (seen.det_row),
        .o_in_zone          (seen.in_zone),
        .o_link_up          (seen.link_up),
        .o_srv_ok           (seen.srv_ok),
        .o_signal_strength  (seen.signal_strength),
        .o_epoch_sec        (seen.epoch_sec)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // decoder mirror state
    bit          kind_sel;
    bit          in_frame;
    int unsigned frame_len;
    logic [7:0]  sum_xor;
    logic [23:0] window;
    int unsigned comma_cnt;
    longint      digit_acc;
    logic [7:0]  flags;
    logic [31:0] fields [6];
    int unsigned held_crs;

    t_result     result_q[$];
    int          errors = 0;
    int          sent_bytes = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          cycles = 0;

    function automatic int unsigned hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return 16;
    endfunction

    function automatic longint field_max(bit net, int unsigned idx);
        case (idx)
            1: return net ? 1 : 65535;
            2: return 1;
            3: return net ? 0 : 100;
            4: return net ? 64'hFFFF_FFFF : 4095;
            5: return 4095;
            default: return 1;
        endcase
    endfunction

    function automatic void end_field();
        bit net;
        bit ok;
        logic [31:0] val;
        net = flags[MK_KIND];
        val = '0;
        if (comma_cnt == 0) begin
            if (flags[MK_BAD] || digit_acc != 3) flags[MK_TYPE] = 1'b1;
        end else if (comma_cnt <= (net ? 4 : 6)) begin
            ok = flags[MK_DIGIT] && !flags[MK_BAD];
            if (ok) begin
                if (net && comma_cnt == 3) begin
                    if (flags[MK_NEG]) begin
                        ok = digit_acc <= 127;
                        val = 32'd0 - digit_acc[31:0];
                    end else begin
                        ok = digit_acc == 0;
                    end
                end else begin
                    ok = !flags[MK_NEG] && digit_acc <= field_max(net, comma_cnt);
                    val = digit_acc[31:0];
                end
            end
            if (ok) fields[comma_cnt-1] = val;
            else flags[MK_NUMBER] = 1'b1;
        end
        flags[MK_NEG:MK_BAD] = '0;
        digit_acc = 0;
        if (comma_cnt < 15) comma_cnt++;
    endfunction

    function automatic void take_payload(logic [7:0] p);
        string tag;
        sum_xor ^= p;
        if (p == CH_COMMA) begin
            end_field();
            return;
        end
        if (comma_cnt == 0) begin
            tag = flags[MK_KIND] ? "NET" : "VIS";
            if (!(digit_acc < 3 && p == tag[digit_acc])) flags[MK_BAD] = 1'b1;
            if (digit_acc < 4) digit_acc++;
            return;
        end
        if (p >= CH_ZERO && p <= CH_NINE) begin
            digit_acc = digit_acc * 10 + (p - CH_ZERO);
            if (digit_acc > 64'h1_0000_0000) digit_acc = 64'h1_0000_0000;
            flags[MK_DIGIT] = 1'b1;
        end else if (p == CH_MINUS && flags[MK_KIND] && comma_cnt == 3 &&
                     !flags[MK_DIGIT] && !flags[MK_NEG] && !flags[MK_BAD]) begin
            flags[MK_NEG] = 1'b1;
        end else begin
            flags[MK_BAD] = 1'b1;
        end
    endfunction

    function automatic void shift_window(logic [7:0] b, int unsigned held);
        if (held >= 3) take_payload(window[23:16]);
        window = {window[15:0], b};
    endfunction

    function automatic t_result close_frame();
        t_result r;
        int unsigned held, hi, lo;
        bit net;
        r = '0;
        held = frame_len - 1 - held_crs;
        net = flags[MK_KIND];
        in_frame = 1'b0;
        if (held < 6 || window[23:16] != CH_STAR) begin
            r.status = ST_ENVELOPE;
            return r;
        end
        hi = hex_nibble(window[15:8]);
        lo = hex_nibble(window[7:0]);
        if (hi > 15 || lo > 15) r.status = ST_ENVELOPE;
        else if (sum_xor != 8'((hi << 4) | lo)) r.status = ST_CHECKSUM;
        else if (comma_cnt != (net ? 4 : 6)) r.status = ST_COUNT;
        else begin
            end_field();
            if (flags[MK_TYPE]) r.status = ST_TYPE;
            else if (flags[MK_NUMBER]) r.status = ST_NUMBER;
            else if (net) begin
                if (fields[1] != 0 && fields[0] == 0) r.status = ST_RANGE;
                else begin
                    r.status = ST_OK;
                    r.link_up         = fields[0][0];
                    r.srv_ok          = fields[1][0];
                    r.signal_strength = fields[2][7:0];
                    r.epoch_sec       = fields[3];
                end
            end else begin
                if (fields[1] == 0 && (fields[2] | fields[3] | fields[4] | fields[5]) != 0)
                    r.status = ST_RANGE;
                else begin
                    r.status = ST_OK;
                    r.sequence_res = fields[0][15:0];
                    r.has_person   = fields[1][0];
                    r.score        = fields[2][6:0];
                    r.det_col      = fields[3][11:0];
                    r.det_row      = fields[4][11:0];
                    r.in_zone      = fields[5][0];
                end
            end
        end
        return r;
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        t_result r;
        int unsigned held;
        if (b == CH_DOLLAR) begin
            in_frame = 1'b1;
            frame_len = 1;
            sum_xor = '0;
            window = '0;
            comma_cnt = 0;
            digit_acc = 0;
            flags = '0;
            flags[MK_KIND] = kind_sel;
            foreach (fields[i]) fields[i] = '0;
            held_crs = 0;
            return;
        end
        if (!in_frame) return;
        if (b == CH_LF) begin
            result_q.push_back(close_frame());
            return;
        end
        if (frame_len >= MAX_FRAME_BYTES) begin
            in_frame = 1'b0;
            frame_len = 0;
            r = '0;
            r.status = ST_DROPPED;
            result_q.push_back(r);
            return;
        end
        held = frame_len - 1 - held_crs;
        frame_len++;
        if (b == CH_CR) begin
            held_crs++;
            return;
        end
        repeat (held_crs) begin
            shift_window(CH_CR, held);
            held++;
        end
        held_crs = 0;
        shift_window(b, held);
    endfunction

    // receiver: stall at random, check every popped beat
    always @(negedge i_clk) pop <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (result_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result\n  expected none\n  actual   %p",
                         $realtime, seen);
            end else begin
                want = result_q.pop_front();
                if (seen !== want) begin
                    errors++;
                    $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                             $realtime, want, seen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk) push <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        predict_byte(b);
        sent_bytes++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // frame a payload: '$', payload, '*', checksum, trailing CRs, newline
    task automatic send_sentence(string payload, bit bad_sum = 0, int crs = 0);
        logic [7:0] x;
        string hx;
        x = '0;
        for (int i = 0; i < payload.len(); i++) x ^= payload[i];
        if (bad_sum) x ^= 8'($urandom_range(1, 255));
        hx = $urandom_range(1) ? $sformatf("%02X", x) : $sformatf("%02x", x);
        send_byte(CH_DOLLAR);
        send_text(payload);
        send_byte(CH_STAR);
        send_text(hx);
        repeat (crs) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // hold until every expected beat is out, then let the pipeline settle
    task automatic drain();
        @(negedge i_clk) push <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_kind(bit v);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        kind_sel = v;
    endtask

    function automatic string vis_text();
        bit person;
        person = $urandom_range(1);
        if (!person && $urandom_range(3) != 0)
            return $sformatf("VIS,%0d,0,0,0,0,0", $urandom_range(65535));
        return $sformatf("VIS,%0d,%0d,%0d,%0d,%0d,%0d", $urandom_range(65535), person,
                         $urandom_range(100), $urandom_range(4095), $urandom_range(4095),
                         $urandom_range(1));
    endfunction

    function automatic string net_text();
        int wifi;
        string rssi;
        wifi = $urandom_range(1);
        rssi = $urandom_range(7) == 0 ? "0" : $sformatf("-%0d", $urandom_range(127));
        return $sformatf("NET,%0d,%0d,%s,%0d", wifi, wifi ? $urandom_range(1) : 0, rssi,
                         $urandom());
    endfunction

    // damage a good sentence: bad tag, extra or missing field, or one bad field
    function automatic string corrupt(string s);
        string junk [10] = '{"", "1a", "-3", "65536", "101", "4096", "2",
                             "99999999999", "-128", "-"};
        string parts [$];
        string out;
        int pos;
        pos = 0;
        for (int i = 0; i <= s.len(); i++) begin
            if (i == s.len() || s[i] == ",") begin
                parts.push_back(s.substr(pos, i - 1));
                pos = i + 1;
            end
        end
        case ($urandom_range(3))
            0: parts[0] = $urandom_range(1) ? "VIX" : "NETS";
            1: parts.push_back($sformatf("%0d", $urandom_range(9)));
            2: void'(parts.pop_back());
            default: parts[$urandom_range(1, parts.size() - 1)] = junk[$urandom_range(9)];
        endcase
        out = parts[0];
        for (int i = 1; i < parts.size(); i++) out = {out, ",", parts[i]};
        return out;
    endfunction

    function automatic string good_text();
        return kind_sel ? net_text() : vis_text();
    endfunction

    task automatic test_reset_and_config();
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        kind_sel = 1'b0;
        in_frame = 1'b0;
        frame_len = 0;
        held_crs = 0;
        write_kind(1'b0);
    endtask

    task automatic test_vis_limits();
        send_sentence("VIS,65535,1,100,4095,4095,1");
        send_sentence("VIS,0,0,0,0,0,0", 0, 2);
        send_sentence("VIS,00012,1,007,0,4095,0");
        send_sentence("VIS,1,0,5,0,0,0");                  // range rule: no person
        send_sentence("VIS,65536,1,100,4095,4095,1");
        send_sentence("VIS,1,1,1,1,1", 0, 1);              // one field short
        send_sentence("NET,1,1,-5,7");                     // wrong kind
        send_sentence("VIS,1,1,1,1,1,1", 1);
    endtask

    task automatic test_net_limits();
        write_kind(1'b1);
        send_sentence("NET,1,1,-127,4294967295");
        send_sentence("NET,0,0,-0,0");
        send_sentence("NET,0,1,-10,5");                    // server without wifi
        send_sentence("NET,1,0,-128,5");
        send_sentence("NET,1,0,5,5");
        send_sentence("NET,1,0,--5,5");
        send_sentence("NET,1,0,-5,4294967296");
    endtask

    task automatic test_framing_cases();
        send_text("ab\r\n*");                              // ignored outside a frame
        send_text("$NE$");                                 // reopen an open frame
        send_sentence("NET,1,1,-1,1");
        send_text("$*0\n");                                // too short
        send_text("$NET,1,1,0,0*G0\n");                    // bad hex digit
        send_text("$NET,1\r1,0,0*00\r\n");                 // carriage return mid-frame
        send_byte(CH_DOLLAR);
        send_byte(8'h00);                                  // zero byte inside a frame
        send_byte(CH_LF);
        send_byte(CH_DOLLAR);
        repeat (MAX_FRAME_BYTES + 2) send_byte("7");       // overflow
        send_byte(CH_LF);
        write_kind(1'b0);
    endtask

    task automatic test_random_traffic();
        int pct [4][2] = '{'{0, 0}, '{84, 0}, '{0, 84}, '{8, 8}};
        int pick;
        sent_bytes = 0;
        for (int ph = 0; ph < 8; ph++) begin
            write_kind(ph[0]);
            idle_pct = pct[ph / 2][0];
            stall_pct = pct[ph / 2][1];
            while (sent_bytes < RANDOM_BYTES * (ph + 1) / 8) begin
                pick = $urandom_range(99);
                if (pick < 60) send_sentence(good_text(), 0, $urandom_range(2));
                else if (pick < 75) send_sentence(corrupt(good_text()), 0, $urandom_range(1));
                else if (pick < 82) send_sentence(good_text(), 1);
                else if (pick < 88) repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom()));
                else if (pick < 93) send_sentence(kind_sel ? vis_text() : net_text());
                else if (pick < 98) begin
                    send_text("$VI\r\r\r\rS,");
                    send_sentence(good_text());
                end else begin
                    send_byte(CH_DOLLAR);
                    repeat (MAX_FRAME_BYTES) send_byte(8'($urandom_range(48, 122)));
                end
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        test_reset_and_config();
        test_vis_limits();
        test_net_limits();
        test_framing_cases();
        test_random_traffic();
        drain();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+sv
sv/csd_pkg.sv
sv/csd_front.sv
sv/csd_evq.sv
sv/csd_back.sv
sv/checksummed_sentence_decoder_top.sv
tb/sv/tb.sv
